>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, quiet while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/spl_pkg.sv
// Types and codes shared by the sorted priority list modules.
package spl_pkg;

   localparam int COUNT_W = 5;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] prio;
      logic [31:0] data;
   } entry_type;

   typedef struct packed {
      logic               top_valid;
      entry_type          top;
      logic [COUNT_W-1:0] count;
      logic [1:0]         status;
   } result_type;

endpackage

>>> rtl/spl_store.sv
// Slot memory: one write port, one read port, registered read data.
module spl_store
   import spl_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_entry,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_entry
);

   entry_type slot_mem [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= slot_mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

>>> rtl/spl_ctrl.sv
// Sequencer: walks the slot memory for add and remove, zeroes the count for clear, then fetches the top entry.
module spl_ctrl
   import spl_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int ADDR_W      = 4,
   parameter int CNT_W       = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  entry_type         req_entry,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output entry_type         wr_entry,
   output logic [ADDR_W-1:0] rd_addr,
   input  entry_type         rd_entry,
   input  logic              res_hold,
   output logic              res_load,
   output result_type        res
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_ADD_RD  = 4'd1;
   localparam logic [3:0] ST_ADD_CMP = 4'd2;
   localparam logic [3:0] ST_RM_RD   = 4'd3;
   localparam logic [3:0] ST_RM_CMP  = 4'd4;
   localparam logic [3:0] ST_SH_RD   = 4'd5;
   localparam logic [3:0] ST_SH_WR   = 4'd6;
   localparam logic [3:0] ST_TOP_RD  = 4'd7;
   localparam logic [3:0] ST_TOP_CAP = 4'd8;

   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   entry_type        entry_ff, entry_in;
   logic [1:0]       status_ff, status_in;

   logic [CNT_W-1:0] top_pos;
   logic [CNT_W-1:0] idx_dec;
   logic [CNT_W-1:0] idx_inc;

   assign top_pos = fill_ff - CNT_ONE;
   assign idx_dec = idx_ff - CNT_ONE;
   assign idx_inc = idx_ff + CNT_ONE;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      entry_in  = entry_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[ADDR_W-1:0];
      wr_entry  = entry_ff;
      rd_addr   = top_pos[ADDR_W-1:0];
      res_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               entry_in  = req_entry;
               status_in = STATUS_OK;
               idx_in    = '0;
               state_in  = ST_TOP_RD;
               case (req_action)
                  ACT_ADD: begin
                     if (fill_ff >= CNT_MAX) begin
                        status_in = STATUS_FULL;
                     end else begin
                        idx_in   = fill_ff;
                        state_in = ST_ADD_RD;
                     end
                  end
                  ACT_REMOVE: begin
                     state_in = ST_RM_RD;
                  end
                  ACT_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                     state_in = ST_TOP_RD;
                  end
               endcase
            end
         end
         ST_ADD_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               fill_in  = fill_ff + CNT_ONE;
               state_in = ST_TOP_RD;
            end else begin
               rd_addr  = idx_dec[ADDR_W-1:0];
               state_in = ST_ADD_CMP;
            end
         end
         ST_ADD_CMP: begin
            wr_en = 1'b1;
            if (entry_ff.prio >= rd_entry.prio) begin
               fill_in  = fill_ff + CNT_ONE;
               state_in = ST_TOP_RD;
            end else begin
               wr_entry = rd_entry;
               idx_in   = idx_dec;
               state_in = ST_ADD_RD;
            end
         end
         ST_RM_RD: begin
            if (idx_ff >= fill_ff) begin
               status_in = STATUS_MISS;
               state_in  = ST_TOP_RD;
            end else begin
               rd_addr  = idx_ff[ADDR_W-1:0];
               state_in = ST_RM_CMP;
            end
         end
         ST_RM_CMP: begin
            if (rd_entry == entry_ff) begin
               state_in = ST_SH_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_RM_RD;
            end
         end
         ST_SH_RD: begin
            if (idx_inc >= fill_ff) begin
               fill_in  = top_pos;
               state_in = ST_TOP_RD;
            end else begin
               rd_addr  = idx_inc[ADDR_W-1:0];
               state_in = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            wr_en    = 1'b1;
            wr_entry = rd_entry;
            idx_in   = idx_inc;
            state_in = ST_SH_RD;
         end
         ST_TOP_RD: begin
            state_in = ST_TOP_CAP;
         end
         ST_TOP_CAP: begin
            if (!res_hold) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.top_valid = (fill_ff != '0);
      res.top       = (fill_ff != '0) ? rd_entry : '0;
      res.count     = COUNT_W'(fill_ff);
      res.status    = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      entry_ff  <= entry_in;
      status_ff <= status_in;
   end

endmodule

>>> rtl/sorted_priority_list_core.sv
// Sorted priority list: up to MAX_ENTRIES entries in a slot memory, kept in priority order.
// Each request (add, remove, clear) returns one response carrying the top entry, the count and
// a status. The slot memory takes one read and one write a cycle, with registered read data.
// An add moves each entry of higher priority than the new one up one slot, then writes the new
// entry; a remove scans from the bottom and, on a hit, shifts the entries above it down one
// slot. Clear, a dropped add and an unused action go straight to the top fetch. A stalled
// response holds the sequencer until it is taken; the next request can be taken at the edge
// after the response reaches the output register.
module sorted_priority_list_core
   import spl_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_entry_id,
   input  logic [15:0]        req_entry_priority,
   input  logic [31:0]        req_entry_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_top_valid,
   output logic [7:0]         rsp_top_id,
   output logic [15:0]        rsp_top_priority,
   output logic [31:0]        rsp_top_data,
   output logic [COUNT_W-1:0] rsp_entry_count,
   output logic [1:0]         rsp_status
);

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

   entry_type           req_entry;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   entry_type           wr_entry;
   logic [ADDR_W-1:0]   rd_addr;
   entry_type           rd_entry;
   logic                res_hold;
   logic                res_load;
   result_type          res;

   logic                rsp_valid_ff;
   result_type          rsp_ff;

   assign req_entry.id   = req_entry_id;
   assign req_entry.prio = req_entry_priority;
   assign req_entry.data = req_entry_data;

   spl_store #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   spl_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_W      (ADDR_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_entry  (req_entry),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_entry   (wr_entry),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry),
      .res_hold   (res_hold),
      .res_load   (res_load),
      .res        (res)
   );

   assign res_hold = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_valid    = rsp_ff.top_valid;
   assign rsp_top_id       = rsp_ff.top.id;
   assign rsp_top_priority = rsp_ff.top.prio;
   assign rsp_top_data     = rsp_ff.top.data;
   assign rsp_entry_count  = rsp_ff.count;
   assign rsp_status       = rsp_ff.status;

endmodule

>>> rtl/spl_checker.sv
// Port-level checks on the sorted priority list, bound to the top level.
`include "assert_macros.svh"

module spl_checker
   import spl_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_top_valid,
   input logic [7:0]         rsp_top_id,
   input logic [15:0]        rsp_top_priority,
   input logic [31:0]        rsp_top_data,
   input logic [COUNT_W-1:0] rsp_entry_count,
   input logic [1:0]         rsp_status
);

   localparam logic WIDE_LIST = (MAX_ENTRIES > 31);

   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable({rsp_top_valid, rsp_top_id, rsp_top_priority, rsp_top_data, rsp_entry_count, rsp_status}))
   `ASSERT_IMPLY(a_top_vs_count, clock, reset, rsp_valid && !WIDE_LIST, rsp_top_valid == (rsp_entry_count != '0))
   `ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && !rsp_top_valid, (rsp_top_id == '0) && (rsp_top_priority == '0) && (rsp_top_data == '0))
   `ASSERT_IMPLY(a_full_count, clock, reset, rsp_valid && (rsp_status == STATUS_FULL) && !WIDE_LIST, rsp_entry_count == COUNT_W'(MAX_ENTRIES))

endmodule

bind sorted_priority_list_core spl_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_spl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_top_valid    (rsp_top_valid),
   .rsp_top_id       (rsp_top_id),
   .rsp_top_priority (rsp_top_priority),
   .rsp_top_data     (rsp_top_data),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_status       (rsp_status)
);
